>>> hw/rtl/tss_pkg.sv
// Task slot scheduler package: slot word layout, state and function codes,
// datapath command codes and the controller/datapath status bundle. No dependencies.
`default_nettype none
package tss_pkg;

  typedef struct packed {
    logic [2:0]  state;
    logic [7:0]  run;
    logic [7:0]  slice;
    logic [31:0] last;
    logic        urg;
    logic        rdy;
    logic        trn;
  } slot_word_t;

  localparam logic [2:0] ST_EMPTY      = 3'd0;
  localparam logic [2:0] ST_ALLOCATING = 3'd1;
  localparam logic [2:0] ST_RUNNING    = 3'd2;
  localparam logic [2:0] ST_WAITING    = 3'd3;
  localparam logic [2:0] ST_SLEEPING   = 3'd4;
  localparam logic [2:0] ST_READY      = 3'd5;
  localparam logic [2:0] ST_WILL_EMPTY = 3'd6;
  localparam logic [2:0] ST_DIED       = 3'd7;

  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_ALLOC   = 3'd1;
  localparam logic [2:0] FN_PUBLISH = 3'd2;
  localparam logic [2:0] FN_WAKE    = 3'd3;
  localparam logic [2:0] FN_BLOCK   = 3'd4;
  localparam logic [2:0] FN_SET     = 3'd5;
  localparam logic [2:0] FN_RUNNOW  = 3'd6;
  localparam logic [2:0] FN_TRAIN   = 3'd7;

  localparam logic CFG_IDLE_SLOT = 1'b0;
  localparam logic CFG_TRAIN_THR = 1'b1;

  localparam logic [7:0] TRAIN_RESET = 8'd5;

  typedef logic [3:0] cmd_t;
  localparam cmd_t CMD_NOP    = 4'd0;
  localparam cmd_t CMD_CLR    = 4'd1;
  localparam cmd_t CMD_LOAD   = 4'd2;
  localparam cmd_t CMD_RD_TGT = 4'd3;
  localparam cmd_t CMD_WR_OP  = 4'd4;
  localparam cmd_t CMD_RD_CUR = 4'd5;
  localparam cmd_t CMD_KEEP   = 4'd6;
  localparam cmd_t CMD_SINIT  = 4'd7;
  localparam cmd_t CMD_SCAN   = 4'd8;
  localparam cmd_t CMD_ASCAN  = 4'd9;
  localparam cmd_t CMD_RD_NXT = 4'd10;
  localparam cmd_t CMD_WR_NXT = 4'd11;
  localparam cmd_t CMD_WR_CUR = 4'd12;

  typedef struct packed {
    logic clr_last;
    logic keep;
    logic scan_done;
    logic alloc_done;
    logic out_busy;
  } dp_status_t;

endpackage
`default_nettype wire

>>> hw/rtl/tss_ctrl.sv
// Task slot scheduler controller: sequences the datapath by command codes.
// Depends on tss_pkg.
`default_nettype none
module tss_ctrl
  import tss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [2:0] in_func,
  input  wire logic       out_stall,
  input  wire dp_status_t sts,
  output logic            in_stall,
  output cmd_t            cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_OPRD  = 4'd2;
  localparam logic [3:0] S_OPWR  = 4'd3;
  localparam logic [3:0] S_TRD   = 4'd4;
  localparam logic [3:0] S_TDEC  = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_NRD   = 4'd7;
  localparam logic [3:0] S_NWR   = 4'd8;
  localparam logic [3:0] S_CRD   = 4'd9;
  localparam logic [3:0] S_CWR   = 4'd10;
  localparam logic [3:0] S_ASCAN = 4'd11;

  logic [3:0] st_r, st_nxt;
  logic       accept;

  assign in_stall = !((st_r == S_IDLE) && (!sts.out_busy || !out_stall));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    st_nxt = st_r;
    cmd    = CMD_NOP;
    unique case (st_r)
      S_CLR: begin
        cmd = CMD_CLR;
        if (sts.clr_last) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd = CMD_LOAD;
          if (in_func == FN_TICK)       st_nxt = S_TRD;
          else if (in_func == FN_ALLOC) st_nxt = S_ASCAN;
          else                          st_nxt = S_OPRD;
        end
      end
      S_OPRD: begin cmd = CMD_RD_TGT; st_nxt = S_OPWR; end
      S_OPWR: begin cmd = CMD_WR_OP;  st_nxt = S_IDLE; end
      S_TRD:  begin cmd = CMD_RD_CUR; st_nxt = S_TDEC; end
      S_TDEC: begin
        if (sts.keep) begin
          cmd = CMD_KEEP;
          st_nxt = S_IDLE;
        end else begin
          cmd = CMD_SINIT;
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (sts.scan_done) st_nxt = S_NRD;
      end
      S_NRD: begin cmd = CMD_RD_NXT; st_nxt = S_NWR; end
      S_NWR: begin cmd = CMD_WR_NXT; st_nxt = S_CRD; end
      S_CRD: begin cmd = CMD_RD_CUR; st_nxt = S_CWR; end
      S_CWR: begin cmd = CMD_WR_CUR; st_nxt = S_IDLE; end
      S_ASCAN: begin
        cmd = CMD_ASCAN;
        if (sts.alloc_done) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_CLR;
    else        st_r <= st_nxt;
  end

endmodule
`default_nettype wire

>>> hw/rtl/tss_dp.sv
// Task slot scheduler datapath: slot table memory, scan pipeline, registers
// and result register. Depends on tss_pkg; driven by tss_ctrl commands.
`default_nettype none
module tss_dp
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS = 256
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output dp_status_t       sts,
  input  wire logic [2:0]  in_func,
  input  wire logic [7:0]  in_slot,
  input  wire logic [2:0]  in_new_state,
  input  wire logic [7:0]  in_time_slice,
  input  wire logic [31:0] in_now_time,
  input  wire logic [31:0] in_timer_count,
  input  wire logic        in_flag_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_result_slot,
  output logic             out_ok,
  output logic             out_switched
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = IW + 8;
  localparam logic [IW:0]   N_PTR  = (IW+1)'(NUM_SLOTS);
  localparam logic [CW-1:0] N_WIDE = CW'(NUM_SLOTS);

  function automatic logic [7:0] to8(input logic [IW-1:0] v);
    logic [IW+7:0] w;
    w = {8'b0, v};
    return w[7:0];
  endfunction

  slot_word_t mem [NUM_SLOTS];

  logic [2:0]  func_r, func_nxt, nst_r, nst_nxt;
  logic [7:0]  slot_r, slot_nxt, slice_r, slice_nxt;
  logic [31:0] now_r, now_nxt, tc_r, tc_nxt;
  logic        flag_r, flag_nxt;
  logic [7:0]  idle_r, thr_r;
  logic [IW-1:0] cur_r, cur_nxt, pend_r, pend_nxt, nxt_r, nxt_nxt;
  logic [IW-1:0] best_r, best_nxt, proc_r, proc_nxt;
  logic        has_cur_r, has_cur_nxt, has_pend_r, has_pend_nxt;
  logic        found_r, found_nxt, best_due_r, best_due_nxt;
  logic [31:0] best_last_r, best_last_nxt;
  logic [IW:0] ptr_r, ptr_nxt;
  logic        rd_valid_r, rd_valid_nxt;
  slot_word_t  rd_data_r, e, wr_data;
  logic        wr_en, rd_en;
  logic [IW-1:0] wr_addr, rd_addr, tgt, sel;
  logic        out_valid_r, out_valid_nxt, out_ok_r, out_ok_nxt, out_sw_r, out_sw_nxt;
  logic [7:0]  out_slot_r, out_slot_nxt;
  logic        slot_ok, due_i, elig, is_urg, scan_done, alloc_done, clr_last;
  logic [IW+7:0] slot_w;
  logic [CW-1:0] idle_w;

  assign e         = rd_data_r;
  assign slot_w    = {{IW{1'b0}}, slot_r};
  assign tgt       = slot_w[IW-1:0];
  assign slot_ok   = slot_w < N_WIDE;
  assign idle_w    = {{IW{1'b0}}, idle_r};
  assign due_i     = e.trn && ((tc_r - e.last) >= {24'b0, thr_r});
  assign elig      = !(has_cur_r && (proc_r == cur_r)) &&
                     ((e.state == ST_RUNNING) || ((e.state == ST_WAITING) && e.rdy));
  assign is_urg    = rd_valid_r && elig && e.urg;
  assign cfg_ready = 1'b1;
  assign clr_last  = (ptr_r == N_PTR - 1'b1);

  assign sts = '{clr_last:   clr_last,
                 keep:       has_cur_r && !has_pend_r && (e.state == ST_RUNNING) &&
                             (({1'b0, e.run} + 9'd1) < {1'b0, e.slice}),
                 scan_done:  scan_done,
                 alloc_done: alloc_done,
                 out_busy:   out_valid_r};

  always_comb begin
    func_nxt = func_r; slot_nxt = slot_r; nst_nxt = nst_r; slice_nxt = slice_r;
    now_nxt = now_r; tc_nxt = tc_r; flag_nxt = flag_r;
    cur_nxt = cur_r; has_cur_nxt = has_cur_r; pend_nxt = pend_r; has_pend_nxt = has_pend_r;
    nxt_nxt = nxt_r; best_nxt = best_r; found_nxt = found_r;
    best_due_nxt = best_due_r; best_last_nxt = best_last_r;
    ptr_nxt = ptr_r; proc_nxt = proc_r; rd_valid_nxt = rd_valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_slot_nxt = out_slot_r; out_ok_nxt = out_ok_r; out_sw_nxt = out_sw_r;
    wr_en = 1'b0; wr_addr = proc_r; wr_data = e;
    rd_en = 1'b0; rd_addr = ptr_r[IW-1:0];
    scan_done = 1'b0; alloc_done = 1'b0;
    sel = '0;
    unique case (cmd)
      CMD_CLR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[IW-1:0];
        wr_data = '0;
        ptr_nxt = clr_last ? '0 : ptr_r + 1'b1;
      end
      CMD_LOAD: begin
        func_nxt = in_func; slot_nxt = in_slot; nst_nxt = in_new_state;
        slice_nxt = in_time_slice; now_nxt = in_now_time; tc_nxt = in_timer_count;
        flag_nxt = in_flag_value;
        // allocation skips slot 0 once something has been dispatched
        ptr_nxt = ((in_func == FN_ALLOC) && has_cur_r) ? (IW+1)'(1) : '0;
        rd_valid_nxt = 1'b0;
      end
      CMD_RD_TGT: begin
        rd_en = 1'b1; rd_addr = tgt;
      end
      CMD_WR_OP: begin
        out_valid_nxt = 1'b1; out_slot_nxt = '0; out_sw_nxt = 1'b0; out_ok_nxt = 1'b0;
        wr_addr = tgt;
        if (slot_ok) begin
          case (func_r)
            FN_PUBLISH: if (e.state == ST_ALLOCATING) begin
              wr_en = 1'b1; wr_data.state = ST_RUNNING; out_ok_nxt = 1'b1;
            end
            FN_WAKE: if ((e.state == ST_RUNNING) || (e.state == ST_WAITING) ||
                         (e.state == ST_SLEEPING)) begin
              wr_en = 1'b1; wr_data.urg = 1'b1; wr_data.rdy = 1'b1; wr_data.run = '0;
              out_ok_nxt = 1'b1;
            end
            FN_BLOCK: begin
              wr_en = 1'b1;
              if (e.rdy) wr_data.rdy = 1'b0;
              else begin
                wr_data.state = nst_r; out_ok_nxt = 1'b1;
              end
            end
            FN_SET: begin
              wr_en = 1'b1; wr_data.state = nst_r; out_ok_nxt = 1'b1;
            end
            FN_RUNNOW: begin
              pend_nxt = tgt; has_pend_nxt = 1'b1; out_ok_nxt = 1'b1;
            end
            FN_TRAIN: begin
              wr_en = 1'b1; wr_data.trn = flag_r; out_ok_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      CMD_RD_CUR: begin
        rd_en = 1'b1; rd_addr = cur_r;
      end
      CMD_KEEP: begin
        wr_en = 1'b1; wr_addr = cur_r; wr_data.run = e.run + 8'd1;
        out_valid_nxt = 1'b1; out_slot_nxt = to8(cur_r); out_ok_nxt = 1'b1; out_sw_nxt = 1'b0;
      end
      CMD_SINIT: begin
        ptr_nxt = has_pend_r ? {1'b0, pend_r} : '0;
        has_pend_nxt = 1'b0; found_nxt = 1'b0; rd_valid_nxt = 1'b0;
        if (!has_pend_r && has_cur_r) begin
          wr_en = 1'b1; wr_addr = cur_r; wr_data.run = '0;
        end
      end
      CMD_SCAN: begin
        if (rd_valid_r && !(has_cur_r && (proc_r == cur_r))) begin
          if (e.state == ST_READY) begin
            wr_en = 1'b1; wr_data.state = ST_EMPTY;
          end else if ((e.state == ST_WAITING) && e.rdy) begin
            wr_en = 1'b1; wr_data.state = ST_RUNNING; wr_data.rdy = 1'b0;
          end
        end
        if (is_urg) begin
          best_nxt = proc_r; found_nxt = 1'b1; scan_done = 1'b1; rd_valid_nxt = 1'b0;
        end else begin
          if (rd_valid_r && elig &&
              (!found_r || (e.last < best_last_r) || (e.run != 8'd0)) &&
              (!found_r || !best_due_r || due_i)) begin
            best_nxt = proc_r; found_nxt = 1'b1;
            best_last_nxt = e.last; best_due_nxt = due_i;
          end
          if (ptr_r != N_PTR) begin
            rd_en = 1'b1; proc_nxt = ptr_r[IW-1:0]; ptr_nxt = ptr_r + 1'b1;
            rd_valid_nxt = 1'b1;
          end else begin
            rd_valid_nxt = 1'b0;
            scan_done = !rd_valid_r;
          end
        end
      end
      CMD_ASCAN: begin
        if (rd_valid_r && (e.state == ST_EMPTY)) begin
          wr_en = 1'b1;
          wr_data = '{state: ST_ALLOCATING, run: 8'd0, slice: slice_r, last: 32'd0,
                      urg: 1'b0, rdy: 1'b0, trn: 1'b0};
          out_valid_nxt = 1'b1; out_slot_nxt = to8(proc_r); out_ok_nxt = 1'b1;
          out_sw_nxt = 1'b0; alloc_done = 1'b1; rd_valid_nxt = 1'b0;
        end else if (ptr_r != N_PTR) begin
          rd_en = 1'b1; proc_nxt = ptr_r[IW-1:0]; ptr_nxt = ptr_r + 1'b1;
          rd_valid_nxt = 1'b1;
        end else begin
          rd_valid_nxt = 1'b0;
          if (!rd_valid_r) begin
            out_valid_nxt = 1'b1; out_slot_nxt = '0; out_ok_nxt = 1'b0;
            out_sw_nxt = 1'b0; alloc_done = 1'b1;
          end
        end
      end
      CMD_RD_NXT: begin
        if (found_r)              sel = best_r;
        else if (idle_w < N_WIDE) sel = idle_w[IW-1:0];
        else                      sel = '0;
        nxt_nxt = sel; rd_en = 1'b1; rd_addr = sel;
      end
      CMD_WR_NXT: begin
        wr_en = 1'b1; wr_addr = nxt_r;
        wr_data.urg = 1'b0; wr_data.rdy = 1'b0; wr_data.last = now_r;
      end
      CMD_WR_CUR: begin
        wr_addr = cur_r;
        if (has_cur_r && (e.state == ST_WILL_EMPTY)) begin
          wr_en = 1'b1; wr_data.state = ST_READY;
        end
        out_valid_nxt = 1'b1; out_slot_nxt = to8(nxt_r); out_ok_nxt = 1'b1;
        out_sw_nxt = !has_cur_r || (nxt_r != cur_r);
        cur_nxt = nxt_r; has_cur_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r      <= '0;
      thr_r       <= TRAIN_RESET;
      has_cur_r   <= 1'b0;
      has_pend_r  <= 1'b0;
      found_r     <= 1'b0;
      ptr_r       <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDLE_SLOT) idle_r <= cfg_data;
        else                            thr_r  <= cfg_data;
      end
      has_cur_r   <= has_cur_nxt;
      has_pend_r  <= has_pend_nxt;
      found_r     <= found_nxt;
      ptr_r       <= ptr_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt; slot_r <= slot_nxt; nst_r <= nst_nxt; slice_r <= slice_nxt;
    now_r <= now_nxt; tc_r <= tc_nxt; flag_r <= flag_nxt;
    cur_r <= cur_nxt; pend_r <= pend_nxt; nxt_r <= nxt_nxt; best_r <= best_nxt;
    best_due_r <= best_due_nxt; best_last_r <= best_last_nxt; proc_r <= proc_nxt;
    out_slot_r <= out_slot_nxt; out_ok_r <= out_ok_nxt; out_sw_r <= out_sw_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_slot = out_slot_r;
  assign out_ok          = out_ok_r;
  assign out_switched    = out_sw_r;

  a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    has_cur_r |-> ({{8{1'b0}}, cur_r} < N_WIDE))
    else $error("current slot outside table");
  a_scan_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_SCAN) && scan_done |=> !rd_valid_r)
    else $error("scan pipeline not drained at end of scan");
  a_nop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CMD_NOP) |-> !wr_en)
    else $error("table written without a command");

endmodule
`default_nettype wire

>>> hw/rtl/task_slot_scheduler.sv
// Task slot scheduler top level: controller plus datapath.
// Depends on tss_pkg, tss_ctrl and tss_dp.
//
// One beat in gives one beat out. After reset the block clears its slot table,
// one slot a cycle, with in_stall held high; configuration writes are taken
// throughout. Set, publish, wake, block, run-now and train operations load the
// beat, read the table, then write it. A tick that keeps the current slot reads
// it, then writes it back; a rescheduling tick walks the table one slot a cycle
// through the single read port, starting at a run-now slot if one is pending,
// and an urgent slot cuts it short. Allocate walks the table the same way until
// it finds an empty slot. The result waits in an output register; the next
// beat is taken once the controller is idle and that register is free or being
// drained.
`default_nettype none
module task_slot_scheduler
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS = 256
)(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_func,
  input  wire logic [7:0]  in_slot,
  input  wire logic [2:0]  in_new_state,
  input  wire logic [7:0]  in_time_slice,
  input  wire logic [31:0] in_now_time,
  input  wire logic [31:0] in_timer_count,
  input  wire logic        in_flag_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_result_slot,
  output logic             out_ok,
  output logic             out_switched
);

  cmd_t       cmd;
  dp_status_t sts;

  // controller: sequences each beat through table reads, writes and scans
  tss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_func(in_func),
    .out_stall(out_stall), .sts(sts), .in_stall(in_stall), .cmd(cmd)
  );

  // datapath: slot table, scan pick logic, registers and result register
  tss_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_func(in_func), .in_slot(in_slot), .in_new_state(in_new_state),
    .in_time_slice(in_time_slice), .in_now_time(in_now_time),
    .in_timer_count(in_timer_count), .in_flag_value(in_flag_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_result_slot(out_result_slot), .out_ok(out_ok), .out_switched(out_switched)
  );

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking bench for task_slot_scheduler: a directed opening, then random beats.
// Depends on tss_pkg and the task_slot_scheduler RTL.
`default_nettype none
module tb_top;
  import tss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 256;
  localparam int LIMIT = 4000000;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  slot;
    logic [2:0]  nst;
    logic [7:0]  slice;
    logic [31:0] now;
    logic [31:0] tc;
    logic        flag;
  } sched_op_t;

  typedef struct packed {
    logic [7:0] rslot;
    logic       ok;
    logic       sw;
  } sched_ans_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_func = '0;
  logic [7:0] in_slot = '0;
  logic [2:0] in_new_state = '0;
  logic [7:0] in_time_slice = '0;
  logic [31:0] in_now_time = '0;
  logic [31:0] in_timer_count = '0;
  logic in_flag_value = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_result_slot;
  logic out_ok;
  logic out_switched;

  task_slot_scheduler #(.NUM_SLOTS(SLOTS)) i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the slot table and scheduler registers.
  logic [2:0]  m_state [SLOTS];
  logic [7:0]  m_run   [SLOTS];
  logic [7:0]  m_slice [SLOTS];
  logic [31:0] m_last  [SLOTS];
  logic        m_urg   [SLOTS];
  logic        m_rdy   [SLOTS];
  logic        m_trn   [SLOTS];
  int unsigned m_cur, m_pend;
  logic [7:0]  m_idle, m_thr;

  sched_op_t  pending_ops[$];
  sched_ans_t expected_ans[$];
  int   sent_cnt, got_cnt, fails;
  bit   stim_done;
  // Hold-off request for the receiver, and sender pause flag.
  int   hold_req;
  bit   sender_pause;

  function automatic bit train_due(int unsigned i, logic [31:0] tc);
    logic [31:0] d;
    d = tc - m_last[i];
    return m_trn[i] && (d >= {24'd0, m_thr});
  endfunction

  // Work out the answer for one beat and advance the shadow table.
  function automatic sched_ans_t schedule_op(sched_op_t op);
    sched_ans_t a;
    bit has_cur, has_pend, found;
    int unsigned nxt, start, first;
    logic [2:0] st;
    a = '0;
    if (op.func == FN_TICK) begin
      has_cur = m_cur < SLOTS;
      has_pend = m_pend < SLOTS;
      if (has_cur && !has_pend && m_state[m_cur] == ST_RUNNING &&
          ({1'b0, m_run[m_cur]} + 9'd1) < {1'b0, m_slice[m_cur]}) begin
        m_run[m_cur]++;
        a.rslot = m_cur[7:0];
        a.ok = 1'b1;
        return a;
      end
      if (!has_pend && has_cur) m_run[m_cur] = '0;
      start = has_pend ? m_pend : 0;
      m_pend = SLOTS;
      found = 0;
      nxt = 0;
      for (int unsigned i = start; i < SLOTS; i++) begin
        if (has_cur && i == m_cur) continue;
        st = m_state[i];
        if (st != ST_RUNNING) begin
          if (st == ST_READY) begin
            m_state[i] = ST_EMPTY;
            continue;
          end
          if (st == ST_WAITING && m_rdy[i]) begin
            m_rdy[i] = 1'b0;
            m_state[i] = ST_RUNNING;
          end else continue;
        end
        if (m_urg[i]) begin
          nxt = i;
          found = 1;
          break;
        end
        if (!found || m_last[i] < m_last[nxt] || m_run[i] != 0) begin
          if (!found || !train_due(nxt, op.tc) || train_due(i, op.tc)) begin
            nxt = i;
            found = 1;
          end
        end
      end
      if (!found) nxt = {24'd0, m_idle};
      m_urg[nxt] = 1'b0;
      m_rdy[nxt] = 1'b0;
      m_last[nxt] = op.now;
      if (has_cur && m_state[m_cur] == ST_WILL_EMPTY) m_state[m_cur] = ST_READY;
      a.rslot = nxt[7:0];
      a.ok = 1'b1;
      a.sw = (!has_cur || nxt != m_cur);
      m_cur = nxt;
      return a;
    end
    if (op.func == FN_ALLOC) begin
      first = (m_cur >= SLOTS && m_state[0] == ST_EMPTY) ? 0 : 1;
      for (int unsigned i = first; i < SLOTS; i++) begin
        if (m_state[i] == ST_EMPTY) begin
          m_run[i] = '0;
          m_slice[i] = op.slice;
          m_last[i] = '0;
          m_urg[i] = 1'b0;
          m_rdy[i] = 1'b0;
          m_trn[i] = 1'b0;
          m_state[i] = ST_ALLOCATING;
          a.rslot = i[7:0];
          a.ok = 1'b1;
          return a;
        end
      end
      return a;
    end
    st = m_state[op.slot];
    case (op.func)
      FN_PUBLISH: begin
        if (st == ST_ALLOCATING) begin
          m_state[op.slot] = ST_RUNNING;
          a.ok = 1'b1;
        end
      end
      FN_WAKE: begin
        if (st != ST_EMPTY && st != ST_ALLOCATING && st != ST_READY &&
            st != ST_WILL_EMPTY && st != ST_DIED) begin
          m_urg[op.slot] = 1'b1;
          m_rdy[op.slot] = 1'b1;
          m_run[op.slot] = '0;
          a.ok = 1'b1;
        end
      end
      FN_BLOCK: begin
        if (m_rdy[op.slot]) m_rdy[op.slot] = 1'b0;
        else begin
          m_state[op.slot] = op.nst;
          a.ok = 1'b1;
        end
      end
      FN_SET: begin
        m_state[op.slot] = op.nst;
        a.ok = 1'b1;
      end
      FN_RUNNOW: begin
        m_pend = {24'd0, op.slot};
        a.ok = 1'b1;
      end
      default: begin
        m_trn[op.slot] = op.flag;
        a.ok = 1'b1;
      end
    endcase
    return a;
  endfunction

  // Driver: bursts of beats with random gaps; a beat stays put while stalled.
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_ans.push_back(schedule_op({in_func, in_slot, in_new_state,
          in_time_slice, in_now_time, in_timer_count, in_flag_value}));
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || sender_pause || pending_ops.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          sched_op_t op;
          op = pending_ops.pop_front();
          in_valid <= 1'b1;
          {in_func, in_slot, in_new_state, in_time_slice, in_now_time,
           in_timer_count, in_flag_value} <= op;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  int stall_phase, hold_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_cnt++;
        if (expected_ans.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          sched_ans_t e;
          e = expected_ans.pop_front();
          if (out_result_slot !== e.rslot) begin
            $error("result_slot exp %0d got %0d", e.rslot, out_result_slot);
            fails++;
          end
          if (out_ok !== e.ok) begin
            $error("ok exp %0d got %0d", e.ok, out_ok);
            fails++;
          end
          if (out_switched !== e.sw) begin
            $error("switched exp %0d got %0d", e.sw, out_switched);
            fails++;
          end
        end
      end
      // Long hold-off when requested, otherwise a rotating stall pattern.
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        stall_phase = (stall_phase + 1) % 300;
        out_stall <= (stall_phase < 100) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
    end
  end

  function automatic sched_op_t rand_op(int unsigned fn);
    sched_op_t op;
    op.func = fn[2:0];
    op.slot = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 15));
    op.nst = 3'($urandom_range(0, 7));
    op.slice = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 4));
    op.now = $urandom;
    op.tc = $urandom;
    op.flag = 1'($urandom_range(0, 1));
    return op;
  endfunction

  function automatic sched_op_t make_op(logic [2:0] f, logic [7:0] s, logic [2:0] n,
                                       logic [7:0] sl, logic [31:0] nw, logic [31:0] t,
                                       logic fl);
    return {f, s, n, sl, nw, t, fl};
  endfunction

  // Wait until the last queued beat has been taken and its result checked.
  task automatic drain_all();
    wait (pending_ops.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (expected_ans.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_IDLE_SLOT) m_idle = val;
    else m_thr = val;
    cfg_valid <= 1'b0;
  endtask

  int cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    for (int i = 0; i < SLOTS; i++) begin
      m_state[i] = ST_EMPTY; m_run[i] = '0; m_slice[i] = '0; m_last[i] = '0;
      m_urg[i] = 1'b0; m_rdy[i] = 1'b0; m_trn[i] = 1'b0;
    end
    m_cur = SLOTS; m_pend = SLOTS; m_idle = '0; m_thr = TRAIN_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: allocate, publish, extremes and refusals.
    pending_ops.push_back(make_op(FN_ALLOC, 8'd0, 3'd0, 8'd255, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_ALLOC, 8'd0, 3'd0, 8'd1, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_PUBLISH, 8'd0, 3'd0, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_PUBLISH, 8'd0, 3'd0, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_WAKE, 8'd200, 3'd0, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_TICK, 8'd0, 3'd0, 8'd0, 32'hFFFF_FFFF, '1, 1'b0));
    pending_ops.push_back(make_op(FN_TICK, 8'd0, 3'd0, 8'd0, 32'd7, '0, 1'b0));
    pending_ops.push_back(make_op(FN_PUBLISH, 8'd1, 3'd0, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd1, 3'd0, 8'd0, '0, '0, 1'b1));
    pending_ops.push_back(make_op(FN_WAKE, 8'd1, 3'd0, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_BLOCK, 8'd1, ST_WAITING, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_BLOCK, 8'd1, ST_WAITING, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_TICK, 8'd0, 3'd0, 8'd0, 32'd9, 32'd100, 1'b0));
    pending_ops.push_back(make_op(FN_SET, 8'd255, ST_WILL_EMPTY, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_SET, 8'd3, ST_READY, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_RUNNOW, 8'd255, 3'd0, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_TICK, 8'd0, 3'd0, 8'd0, 32'd11, '0, 1'b0));
    pending_ops.push_back(make_op(FN_SET, 8'd255, ST_DIED, 8'd0, '0, '0, 1'b0));
    pending_ops.push_back(make_op(FN_TICK, 8'd0, 3'd0, 8'd0, 32'd12, '0, 1'b0));
    pending_ops.push_back(make_op(FN_TRAIN, 8'd1, 3'd0, 8'd0, '0, '0, 1'b0));
    drain_all();
    write_reg(CFG_IDLE_SLOT, 8'd255);
    write_reg(CFG_TRAIN_THR, 8'd0);

    // Random phases: mostly allocate/publish/tick traffic, plus every other op.
    for (int ph = 0; ph < 5; ph++) begin
      for (int n = 0; n < 330; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) pending_ops.push_back(rand_op(FN_TICK));
        else if (pick < 45) pending_ops.push_back(rand_op(FN_ALLOC));
        else if (pick < 58) pending_ops.push_back(rand_op(FN_PUBLISH));
        else pending_ops.push_back(rand_op($urandom_range(3, 7)));
      end
      if (ph == 1) begin
        // Hold the receiver back so the block backs up onto its input.
        hold_req = 2000;
      end
      if (ph == 3) begin
        // Pause the sender until the block is empty, then resume.
        wait (pending_ops.size() < 150);
        sender_pause = 1'b1;
        wait (expected_ans.size() == 0 && !in_valid);
        repeat (300) @(posedge clk);
        sender_pause = 1'b0;
      end
      drain_all();
      write_reg(CFG_IDLE_SLOT, (ph % 2) ? 8'd0 : 8'($urandom_range(0, 255)));
      write_reg(CFG_TRAIN_THR, (ph == 2) ? 8'd255 : 8'($urandom_range(0, 8)));
    end
    drain_all();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
